// ----- src/kmlrc_pkg.sv -----
// Shared constants and types for the key, light-mode and radio controller.
// No dependencies; used by every other file of the block.
`default_nettype none
package kmlrc_pkg;

  localparam int TIMER_BITS_DEFAULT = 8;
  localparam int LIMIT_W            = 8;
  localparam int PRE_W              = 5;
  localparam int CFG_INDEX_W        = 3;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEBOUNCE_LIMIT        = 3'd0,
    CFG_CONNECT_LOW_LIMIT     = 3'd1,
    CFG_DISCONNECT_HIGH_LIMIT = 3'd2,
    CFG_IDLE_SLEEP_UNITS      = 3'd3,
    CFG_MS_PER_UNIT           = 3'd4,
    CFG_UNITS_PER_BLINK       = 3'd5
  } cfg_index_t;

  localparam logic [LIMIT_W-1:0] DEBOUNCE_LIMIT_RST        = 8'd35;
  localparam logic [LIMIT_W-1:0] CONNECT_LOW_LIMIT_RST     = 8'd150;
  localparam logic [LIMIT_W-1:0] DISCONNECT_HIGH_LIMIT_RST = 8'd250;
  localparam logic [LIMIT_W-1:0] IDLE_SLEEP_UNITS_RST      = 8'd200;
  localparam logic [PRE_W-1:0]   MS_PER_UNIT_RST           = 5'd25;
  localparam logic [PRE_W-1:0]   UNITS_PER_BLINK_RST       = 5'd20;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_HALF = 2'd1,
    MODE_FULL = 2'd2
  } light_mode_t;

  // Per-key debounce result handed to the top level
  typedef struct packed {
    logic press;
    logic held;
  } key_status_t;

endpackage
`default_nettype wire

// ----- src/kmlrc_debounce.sv -----
// Debouncer for one active-low key: stable-time counter and fresh-press detect.
// Depends on kmlrc_pkg.
`default_nettype none
module kmlrc_debounce #(
  parameter int TIMER_BITS = kmlrc_pkg::TIMER_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           advance,
  input  wire logic                           level,
  input  wire logic [kmlrc_pkg::LIMIT_W-1:0]  limit,
  output kmlrc_pkg::key_status_t              status
);

  logic                  stable, stable_next;
  logic                  held, held_next;
  logic [TIMER_BITS-1:0] timer, timer_next, timer_inc;

  always_comb begin
    timer_inc   = (timer == '1) ? timer : timer + 1'b1;
    stable_next = stable;
    held_next   = held;
    timer_next  = timer_inc;
    status.press = 1'b0;
    if (level != stable) begin
      if (timer_inc > TIMER_BITS'(limit)) begin
        stable_next = level;
        timer_next  = '0;
      end
    end else begin
      // level matches: restart the count, press on a fresh low
      timer_next   = '0;
      held_next    = ~stable;
      status.press = ~stable & ~held;
    end
    status.held = held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b0;
      held   <= 1'b0;
      timer  <= '0;
    end else if (advance) begin
      stable <= stable_next;
      held   <= held_next;
      timer  <= timer_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/key_mode_light_radio_controller.sv -----
// Top level of the key, light-mode and radio controller: tick stream in, status out.
// Depends on kmlrc_pkg and kmlrc_debounce.
//
//   channel   dir  width  carries
//   s_axis    in   8      one 1 ms tick of sampled pin levels
//   m_axis    out  8      light, radio and sleep status after that tick
//   cfg       in   8      limit and period registers, write only
//
// One tick is taken per cycle, unless a held result stalls it: the whole update is one
// pass of logic from the state registers into the state and the output register.
// The result of an input transfer is registered and valid in the cycle after it.
// A held result stalls the input only when the output register is full and not taken.
// Reset clears all state but m_axis_tdata, restores the defaults; no clearing pass.
`default_nettype none
module key_mode_light_radio_controller #(
  parameter int TIMER_BITS = kmlrc_pkg::TIMER_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  // [0] key_mode_level, [1] key_radio_level, [2] radio_status_level, [7:3] zero
  input  wire logic [kmlrc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [0] light_enable_one, [1] light_enable_two, [3:2] light_mode, [4] radio_power,
  // [5] radio_led, [6] radio_connected, [7] sleep_request
  output      logic [kmlrc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [kmlrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [kmlrc_pkg::LIMIT_W-1:0]      cfg_wdata
);

  localparam int LW = kmlrc_pkg::LIMIT_W;
  localparam int PW = kmlrc_pkg::PRE_W;

  // configuration
  logic [LW-1:0] debounce_limit, connect_low_limit, disconnect_high_limit;
  logic [LW-1:0] idle_sleep_units;
  logic [PW-1:0] ms_per_unit, units_per_blink;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit        <= kmlrc_pkg::DEBOUNCE_LIMIT_RST;
      connect_low_limit     <= kmlrc_pkg::CONNECT_LOW_LIMIT_RST;
      disconnect_high_limit <= kmlrc_pkg::DISCONNECT_HIGH_LIMIT_RST;
      idle_sleep_units      <= kmlrc_pkg::IDLE_SLEEP_UNITS_RST;
      ms_per_unit           <= kmlrc_pkg::MS_PER_UNIT_RST;
      units_per_blink       <= kmlrc_pkg::UNITS_PER_BLINK_RST;
    end else if (cfg_we) begin
      case (kmlrc_pkg::cfg_index_t'(cfg_index))
        kmlrc_pkg::CFG_DEBOUNCE_LIMIT:        debounce_limit        <= cfg_wdata;
        kmlrc_pkg::CFG_CONNECT_LOW_LIMIT:     connect_low_limit     <= cfg_wdata;
        kmlrc_pkg::CFG_DISCONNECT_HIGH_LIMIT: disconnect_high_limit <= cfg_wdata;
        kmlrc_pkg::CFG_IDLE_SLEEP_UNITS:      idle_sleep_units      <= cfg_wdata;
        kmlrc_pkg::CFG_MS_PER_UNIT:           ms_per_unit           <= cfg_wdata[PW-1:0];
        kmlrc_pkg::CFG_UNITS_PER_BLINK:       units_per_blink       <= cfg_wdata[PW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic tick;
  assign s_axis_tready = ~rst & (~m_axis_tvalid | m_axis_tready);
  assign tick          = s_axis_tvalid & s_axis_tready;

  logic key_mode_level, key_radio_level, radio_status_level;
  assign key_mode_level     = s_axis_tdata[0];
  assign key_radio_level    = s_axis_tdata[1];
  assign radio_status_level = s_axis_tdata[2];

  kmlrc_pkg::key_status_t mode_key, radio_key;

  kmlrc_debounce #(.TIMER_BITS(TIMER_BITS)) u_mode_key (
    .clk     (clk),
    .rst     (rst),
    .advance (tick),
    .level   (key_mode_level),
    .limit   (debounce_limit),
    .status  (mode_key)
  );

  kmlrc_debounce #(.TIMER_BITS(TIMER_BITS)) u_radio_key (
    .clk     (clk),
    .rst     (rst),
    .advance (tick),
    .level   (key_radio_level),
    .limit   (debounce_limit),
    .status  (radio_key)
  );

  // state
  logic [PW-1:0]         ms_prescale, ms_prescale_next, ms_pre_inc;
  logic [PW-1:0]         unit_prescale, unit_prescale_next, unit_pre_inc;
  kmlrc_pkg::light_mode_t mode_value, mode_value_next;
  logic                  radio_on, radio_on_next;
  logic                  link_flag, link_flag_next;
  logic                  led_state, led_state_next;
  logic [TIMER_BITS-1:0] low_time, low_time_next;
  logic [TIMER_BITS-1:0] high_time, high_time_next;
  logic [TIMER_BITS-1:0] idle_time, idle_time_next;
  logic                  unit_tick, blink_tick, sleep;

  always_comb begin
    ms_pre_inc         = (ms_prescale == '1) ? ms_prescale : ms_prescale + 1'b1;
    unit_pre_inc       = (unit_prescale == '1) ? unit_prescale : unit_prescale + 1'b1;
    ms_prescale_next   = ms_pre_inc;
    unit_prescale_next = unit_prescale;
    unit_tick          = 1'b0;
    blink_tick         = 1'b0;
    if (ms_pre_inc >= ms_per_unit) begin
      ms_prescale_next   = '0;
      unit_prescale_next = unit_pre_inc;
      unit_tick          = 1'b1;
      if (unit_pre_inc >= units_per_blink) begin
        unit_prescale_next = '0;
        blink_tick         = 1'b1;
      end
    end

    // status pin timers run on the power state held before this tick
    low_time_next  = low_time;
    high_time_next = high_time;
    if (radio_on) begin
      if (!radio_status_level) begin
        if (!link_flag) begin
          low_time_next  = (low_time == '1) ? low_time : low_time + 1'b1;
          high_time_next = '0;
        end
      end else begin
        low_time_next  = '0;
        high_time_next = (high_time == '1) ? high_time : high_time + 1'b1;
      end
    end else begin
      low_time_next  = '0;
      high_time_next = '0;
    end

    idle_time_next = idle_time;
    if (unit_tick) begin
      idle_time_next = (idle_time == '1) ? idle_time : idle_time + 1'b1;
    end

    led_state_next = led_state;
    if (blink_tick && radio_on && !link_flag) begin
      led_state_next = ~led_state;
    end

    mode_value_next = mode_value;
    if (mode_key.press) begin
      unique case (mode_value)
        kmlrc_pkg::MODE_OFF:  mode_value_next = kmlrc_pkg::MODE_HALF;
        kmlrc_pkg::MODE_HALF: mode_value_next = kmlrc_pkg::MODE_FULL;
        default:              mode_value_next = kmlrc_pkg::MODE_OFF;
      endcase
    end
    radio_on_next = radio_on ^ radio_key.press;

    link_flag_next = link_flag;
    if (radio_on_next) begin
      if (link_flag) begin
        led_state_next = 1'b1;
      end
    end else begin
      led_state_next = 1'b0;
      link_flag_next = 1'b0;
    end
    if (low_time_next > TIMER_BITS'(connect_low_limit)) begin
      link_flag_next = 1'b1;
      low_time_next  = '0;
    end
    if (high_time_next > TIMER_BITS'(disconnect_high_limit)) begin
      link_flag_next = 1'b0;
      high_time_next = '0;
    end

    if ((mode_value_next != kmlrc_pkg::MODE_OFF) || radio_on_next) begin
      idle_time_next = '0;
    end
    sleep = 1'b0;
    if (idle_time_next >= TIMER_BITS'(idle_sleep_units)) begin
      sleep          = 1'b1;
      idle_time_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_prescale   <= '0;
      unit_prescale <= '0;
      mode_value    <= kmlrc_pkg::MODE_OFF;
      radio_on      <= 1'b0;
      link_flag     <= 1'b0;
      led_state     <= 1'b0;
      low_time      <= '0;
      high_time     <= '0;
      idle_time     <= '0;
    end else if (tick) begin
      ms_prescale   <= ms_prescale_next;
      unit_prescale <= unit_prescale_next;
      mode_value    <= mode_value_next;
      radio_on      <= radio_on_next;
      link_flag     <= link_flag_next;
      led_state     <= led_state_next;
      low_time      <= low_time_next;
      high_time     <= high_time_next;
      idle_time     <= idle_time_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (tick) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      m_axis_tdata <= {sleep, link_flag_next, led_state_next, radio_on_next,
                       mode_value_next,
                       mode_value_next == kmlrc_pkg::MODE_FULL,
                       mode_value_next != kmlrc_pkg::MODE_OFF};
    end
  end

endmodule
`default_nettype wire

// ----- src/kmlrc_checker.sv -----
// Port-level checks for the key, light-mode and radio controller, bound to the top.
// Depends on kmlrc_pkg and key_mode_light_radio_controller.
`default_nettype none
module kmlrc_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_axis_tvalid,
  input wire logic                               s_axis_tready,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [kmlrc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // every accepted tick yields a result on the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  // stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // the LED is only driven while the radio is powered
  a_led_power: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[5] && !m_axis_tdata[4]))
    else $error("radio LED on with radio off");

  // light enables follow the reported mode
  a_enables: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[0] == (m_axis_tdata[3:2] != 2'd0)) &&
                       (m_axis_tdata[1] == (m_axis_tdata[3:2] == 2'd2))))
    else $error("light enables disagree with mode");

endmodule

bind key_mode_light_radio_controller kmlrc_checker u_kmlrc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- bench/key_mode_light_radio_controller_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the key, light-mode and radio controller: drives 1 ms tick
// transfers, predicts each status transfer in-line and compares it field by field.
// Depends on kmlrc_pkg and the key_mode_light_radio_controller top level.
module key_mode_light_radio_controller_tb;

  localparam int TMR_W       = kmlrc_pkg::TIMER_BITS_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int KEY_LAMP    = 0;
  localparam int KEY_RADIO   = 1;

  typedef struct packed {
    logic                   sleep_req;
    logic                   linked;
    logic                   led_on;
    logic                   powered;
    kmlrc_pkg::light_mode_t mode;
    logic                   lamp_two;
    logic                   lamp_one;
  } lamp_status_t;

  // pins: [0] light key, [1] radio key, [2] status pin; keys and link are active low
  typedef struct packed {
    logic [2:0] pins;
    bit         fast_limits;
    bit         typed;
    logic [7:0] want;
  } tick_row_t;

  localparam tick_row_t DIRECTED [29] = '{
    // released keys straight after reset: nothing moves yet
    '{3'b111, 1'b0, 1'b1, 8'h00},
    '{3'b111, 1'b0, 1'b1, 8'h00},
    // both keys low: debounced level starts pressed, so this is one press each
    '{3'b100, 1'b0, 1'b1, 8'h15},
    '{3'b100, 1'b0, 1'b1, 8'h15},
    // shortest limits from here: release, step the mode twice, link, unlink
    '{3'b111, 1'b1, 1'b0, 8'h00},
    '{3'b111, 1'b0, 1'b0, 8'h00},
    '{3'b111, 1'b0, 1'b0, 8'h00},
    '{3'b110, 1'b0, 1'b0, 8'h00},
    '{3'b110, 1'b0, 1'b0, 8'h00},
    '{3'b110, 1'b0, 1'b0, 8'h00},
    '{3'b111, 1'b0, 1'b0, 8'h00},
    '{3'b111, 1'b0, 1'b0, 8'h00},
    '{3'b111, 1'b0, 1'b0, 8'h00},
    '{3'b110, 1'b0, 1'b0, 8'h00},
    '{3'b110, 1'b0, 1'b0, 8'h00},
    '{3'b110, 1'b0, 1'b0, 8'h00},
    '{3'b011, 1'b0, 1'b0, 8'h00},
    '{3'b011, 1'b0, 1'b0, 8'h00},
    '{3'b011, 1'b0, 1'b0, 8'h00},
    '{3'b111, 1'b0, 1'b0, 8'h00},
    '{3'b111, 1'b0, 1'b0, 8'h00},
    '{3'b111, 1'b0, 1'b0, 8'h00},
    // radio off, then idle ticks raise sleep requests
    '{3'b101, 1'b0, 1'b0, 8'h00},
    '{3'b101, 1'b0, 1'b0, 8'h00},
    '{3'b101, 1'b0, 1'b0, 8'h00},
    '{3'b111, 1'b0, 1'b0, 8'h00},
    // single-tick glitch on the light key must not pass the debounce
    '{3'b110, 1'b0, 1'b0, 8'h00},
    '{3'b111, 1'b0, 1'b0, 8'h00},
    '{3'b111, 1'b0, 1'b0, 8'h00}
  };

  logic                              clk           = 1'b0;
  logic                              rst           = 1'b1;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [kmlrc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [kmlrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                              cfg_we        = 1'b0;
  kmlrc_pkg::cfg_index_t             cfg_index     = kmlrc_pkg::CFG_DEBOUNCE_LIMIT;
  logic [kmlrc_pkg::LIMIT_W-1:0]     cfg_wdata     = '0;

  // register copies
  logic [kmlrc_pkg::LIMIT_W-1:0] lim_debounce   = kmlrc_pkg::DEBOUNCE_LIMIT_RST;
  logic [kmlrc_pkg::LIMIT_W-1:0] lim_connect    = kmlrc_pkg::CONNECT_LOW_LIMIT_RST;
  logic [kmlrc_pkg::LIMIT_W-1:0] lim_disconnect = kmlrc_pkg::DISCONNECT_HIGH_LIMIT_RST;
  logic [kmlrc_pkg::LIMIT_W-1:0] lim_idle       = kmlrc_pkg::IDLE_SLEEP_UNITS_RST;
  logic [kmlrc_pkg::PRE_W-1:0]   lim_ms_unit    = kmlrc_pkg::MS_PER_UNIT_RST;
  logic [kmlrc_pkg::PRE_W-1:0]   lim_blink      = kmlrc_pkg::UNITS_PER_BLINK_RST;

  // controller state as predicted
  logic [kmlrc_pkg::PRE_W-1:0] ms_count   = '0;
  logic [kmlrc_pkg::PRE_W-1:0] unit_count = '0;
  logic [1:0]                  key_level  = '0;
  logic [1:0]                  key_down   = '0;
  logic [TMR_W-1:0]            key_timer [2] = '{'0, '0};
  kmlrc_pkg::light_mode_t      lamp_mode  = kmlrc_pkg::MODE_OFF;
  logic                        radio_up   = 1'b0;
  logic                        linked     = 1'b0;
  logic [TMR_W-1:0]            low_ms     = '0;
  logic [TMR_W-1:0]            high_ms    = '0;
  logic                        led_on     = 1'b0;
  logic [TMR_W-1:0]            idle_units = '0;

  lamp_status_t expected_status [$];
  bit calm      = 1'b0;
  int hold_ask  = 0;
  int errors    = 0;
  int ticks_sent   = 0;
  int results_seen = 0;
  int settings_run = 1;
  int sleep_pulses = 0;
  int linked_seen  = 0;

  key_mode_light_radio_controller dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic key_press(input int k, input logic level);
    logic pressed;
    pressed = 1'b0;
    if (level != key_level[k]) begin
      if (key_timer[k] > lim_debounce) begin
        key_level[k] = level;
        key_timer[k] = '0;
      end
    end else begin
      key_timer[k] = '0;
      pressed = !key_level[k] && !key_down[k];
      key_down[k] = !key_level[k];
    end
    return pressed;
  endfunction

  function automatic lamp_status_t predict_tick(input logic [2:0] pins);
    logic         unit_tick;
    logic         blink_tick;
    logic         sleep;
    lamp_status_t st;
    unit_tick  = 1'b0;
    blink_tick = 1'b0;
    sleep      = 1'b0;
    if (ms_count != '1) ms_count++;
    if (ms_count >= lim_ms_unit) begin
      ms_count = '0;
      if (unit_count != '1) unit_count++;
      unit_tick = 1'b1;
      if (unit_count >= lim_blink) begin
        unit_count = '0;
        blink_tick = 1'b1;
      end
    end
    for (int k = 0; k < 2; k++)
      if (key_timer[k] != '1) key_timer[k]++;
    if (radio_up) begin
      if (!pins[2]) begin
        // hold the low-time count once linked
        if (!linked) begin
          if (low_ms != '1) low_ms++;
          high_ms = '0;
        end
      end else begin
        low_ms = '0;
        if (high_ms != '1) high_ms++;
      end
    end else begin
      low_ms  = '0;
      high_ms = '0;
    end
    if (unit_tick && idle_units != '1) idle_units++;
    if (blink_tick && radio_up && !linked) led_on = !led_on;

    if (key_press(KEY_LAMP, pins[0])) begin
      case (lamp_mode)
        kmlrc_pkg::MODE_OFF:  lamp_mode = kmlrc_pkg::MODE_HALF;
        kmlrc_pkg::MODE_HALF: lamp_mode = kmlrc_pkg::MODE_FULL;
        default:              lamp_mode = kmlrc_pkg::MODE_OFF;
      endcase
    end
    if (key_press(KEY_RADIO, pins[1])) radio_up = !radio_up;

    if (radio_up) begin
      if (linked) led_on = 1'b1;
    end else begin
      led_on = 1'b0;
      linked = 1'b0;
    end
    // a timer expiring on the power-off tick still sets the flag for that tick
    if (low_ms > lim_connect) begin
      linked = 1'b1;
      low_ms = '0;
    end
    if (high_ms > lim_disconnect) begin
      linked  = 1'b0;
      high_ms = '0;
    end
    if (lamp_mode != kmlrc_pkg::MODE_OFF || radio_up) idle_units = '0;
    if (idle_units >= lim_idle) begin
      sleep      = 1'b1;
      idle_units = '0;
    end

    st.lamp_one  = (lamp_mode == kmlrc_pkg::MODE_HALF || lamp_mode == kmlrc_pkg::MODE_FULL);
    st.lamp_two  = (lamp_mode == kmlrc_pkg::MODE_FULL);
    st.mode      = lamp_mode;
    st.powered   = radio_up;
    st.led_on    = led_on;
    st.linked    = linked;
    st.sleep_req = sleep;
    return st;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
               results_seen, what, got, want);
  endtask

  // Entered and left at a falling edge.
  task automatic send_tick(input logic [2:0] pins, input bit typed, input logic [7:0] want);
    lamp_status_t predicted;
    if (!calm && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 23);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(kmlrc_pkg::IN_TDATA_W-3){1'b0}}, pins};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    predicted = predict_tick(pins);
    expected_status.push_back(typed ? lamp_status_t'(want) : predicted);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input kmlrc_pkg::cfg_index_t idx,
                           input logic [kmlrc_pkg::LIMIT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      kmlrc_pkg::CFG_DEBOUNCE_LIMIT:        lim_debounce   = val;
      kmlrc_pkg::CFG_CONNECT_LOW_LIMIT:     lim_connect    = val;
      kmlrc_pkg::CFG_DISCONNECT_HIGH_LIMIT: lim_disconnect = val;
      kmlrc_pkg::CFG_IDLE_SLEEP_UNITS:      lim_idle       = val;
      kmlrc_pkg::CFG_MS_PER_UNIT:           lim_ms_unit    = val[kmlrc_pkg::PRE_W-1:0];
      kmlrc_pkg::CFG_UNITS_PER_BLINK:       lim_blink      = val[kmlrc_pkg::PRE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drain every outstanding status transfer, then rewrite all six registers.
  task automatic apply_limits(input logic [7:0] db, input logic [7:0] con,
                              input logic [7:0] dis, input logic [7:0] idl,
                              input logic [7:0] per_unit, input logic [7:0] per_blink);
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
    write_reg(kmlrc_pkg::CFG_DEBOUNCE_LIMIT, db);
    write_reg(kmlrc_pkg::CFG_CONNECT_LOW_LIMIT, con);
    write_reg(kmlrc_pkg::CFG_DISCONNECT_HIGH_LIMIT, dis);
    write_reg(kmlrc_pkg::CFG_IDLE_SLEEP_UNITS, idl);
    write_reg(kmlrc_pkg::CFG_MS_PER_UNIT, per_unit);
    write_reg(kmlrc_pkg::CFG_UNITS_PER_BLINK, per_blink);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Pins are held for random runs so that presses and link changes get through
  // the debounce; a few single-tick flips act as noise.
  task automatic run_phase(input logic [7:0] db, input logic [7:0] con,
                           input logic [7:0] dis, input logic [7:0] idl,
                           input logic [7:0] per_unit, input logic [7:0] per_blink,
                           input int n_ticks, input int max_run, input int noise_pct,
                           input bit quiet_phase, input int hold_cycles);
    logic [2:0] lvl;
    logic [2:0] pins;
    int         run_left [3];
    int         flip;
    apply_limits(db, con, dis, idl, per_unit, per_blink);
    calm     = quiet_phase;
    hold_ask = hold_cycles;
    lvl      = 3'b111;
    foreach (run_left[k]) run_left[k] = 0;
    for (int i = 0; i < n_ticks; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (run_left[k] == 0) begin
          lvl[k]      = 1'($urandom_range(1));
          run_left[k] = $urandom_range(1, max_run);
        end
        run_left[k]--;
      end
      pins = lvl;
      if ($urandom_range(99) < noise_pct) begin
        flip       = $urandom_range(2);
        pins[flip] = !pins[flip];
      end
      send_tick(pins, 1'b0, '0);
    end
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_ask != 0) begin
        hold_left = hold_ask;
        hold_ask  = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  always @(posedge clk) begin : check_results
    lamp_status_t got;
    lamp_status_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = lamp_status_t'(m_axis_tdata);
      results_seen++;
      if (got.sleep_req) sleep_pulses++;
      if (got.linked) linked_seen++;
      if (expected_status.size() == 0) begin
        report_mismatch("status transfer with none pending", m_axis_tdata, 0);
      end else begin
        want = expected_status.pop_front();
        if (got.lamp_one !== want.lamp_one)
          report_mismatch("light_enable_one", got.lamp_one, want.lamp_one);
        if (got.lamp_two !== want.lamp_two)
          report_mismatch("light_enable_two", got.lamp_two, want.lamp_two);
        if (got.mode !== want.mode)
          report_mismatch("light_mode", got.mode, want.mode);
        if (got.powered !== want.powered)
          report_mismatch("radio_power", got.powered, want.powered);
        if (got.led_on !== want.led_on)
          report_mismatch("radio_led", got.led_on, want.led_on);
        if (got.linked !== want.linked)
          report_mismatch("radio_connected", got.linked, want.linked);
        if (got.sleep_req !== want.sleep_req)
          report_mismatch("sleep_request", got.sleep_req, want.sleep_req);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Stalled for %0d cycles with %0d status transfers pending",
             STALL_LIMIT, expected_status.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].fast_limits)
        apply_limits(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
      send_tick(DIRECTED[r].pins, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // short limits with a long receiver hold-off to back up the input
    run_phase(8'($urandom_range(1, 3)), 8'($urandom_range(1, 4)),
              8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
              8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
              300, 8, 10, 1'b0, 60);
    // zero periods: every tick a unit boundary, sleep on every tick
    run_phase(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 100, 4, 10, 1'b0, 0);
    // no idling on either side
    run_phase(8'($urandom_range(1, 10)), 8'($urandom_range(1, 20)),
              8'($urandom_range(1, 20)), 8'($urandom_range(1, 10)),
              8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)),
              300, 30, 5, 1'b1, 0);
    run_phase(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 100, 6, 10, 1'b0, 0);
    // top of every range; keys must be held for over 254 ticks
    run_phase(8'd254, 8'd254, 8'd254, 8'd255, 8'd31, 8'd31, 400, 300, 0, 1'b0, 0);
    run_phase(kmlrc_pkg::DEBOUNCE_LIMIT_RST, kmlrc_pkg::CONNECT_LOW_LIMIT_RST,
              kmlrc_pkg::DISCONNECT_HIGH_LIMIT_RST, kmlrc_pkg::IDLE_SLEEP_UNITS_RST,
              8'(kmlrc_pkg::MS_PER_UNIT_RST), 8'(kmlrc_pkg::UNITS_PER_BLINK_RST),
              150, 60, 5, 1'b0, 40);

    s_axis_tvalid <= 1'b0;
    calm = 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d ticks under %0d register settings, checked %0d status transfers",
             ticks_sent, settings_run, results_seen);
    $display("Saw %0d sleep requests and %0d linked ticks; %0d field mismatches",
             sleep_pulses, linked_seen, errors);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
